/* hdl/utf8v_pkg.sv */
package utf8v_pkg;

    localparam int ByteW  = 8;
    localparam int CpW    = 21;
    localparam int LenW   = 3;

    localparam logic [LenW-1:0] CountSat = LenW'(5);
    localparam logic [LenW-1:0] MaxLen   = LenW'(4);

    localparam logic [CpW-1:0] CpMax    = CpW'(32'h10ffff);
    localparam logic [CpW-1:0] SurrLo   = CpW'(32'hd800);
    localparam logic [CpW-1:0] SurrHi   = CpW'(32'hdfff);
    localparam logic [CpW-1:0] DelLo    = CpW'(32'h7f);
    localparam logic [CpW-1:0] C1Hi     = CpW'(32'h9f);
    localparam logic [CpW-1:0] PrintLo  = CpW'(32'h20);
    localparam logic [CpW-1:0] Min2     = CpW'(32'h80);
    localparam logic [CpW-1:0] Min3     = CpW'(32'h800);
    localparam logic [CpW-1:0] Min4     = CpW'(32'h10000);

    localparam logic [ByteW-1:0] Mask3 = 8'he0;
    localparam logic [ByteW-1:0] Mask4 = 8'hf0;
    localparam logic [ByteW-1:0] Mask5 = 8'hf8;

    typedef struct packed {
        logic [LenW-1:0] len;
        logic [CpW-1:0]  payload;
        logic            err;
    } t_lead;

    function automatic t_lead classify_lead(input logic [ByteW-1:0] b);
        t_lead res;
        res = '{len: '0, payload: '0, err: 1'b0};
        if (b[7] == 1'b0) begin
            res.len     = LenW'(1);
            res.payload = CpW'(b);
        end else if ((b & Mask3) == 8'hc0) begin
            res.len     = LenW'(2);
            res.payload = CpW'(b[4:0]);
        end else if ((b & Mask4) == 8'he0) begin
            res.len     = LenW'(3);
            res.payload = CpW'(b[3:0]);
        end else if ((b & Mask5) == 8'hf0) begin
            res.len     = LenW'(4);
            res.payload = CpW'(b[2:0]);
        end else begin
            res.err = 1'b1;
        end
        return res;
    endfunction

    function automatic logic value_ok(input logic [LenW-1:0] len, input logic [CpW-1:0] cp);
        logic ok;
        ok = 1'b1;
        if (len == LenW'(2) && cp < Min2) ok = 1'b0;
        if (len == LenW'(3) && cp < Min3) ok = 1'b0;
        if (len == LenW'(4) && cp < Min4) ok = 1'b0;
        if (cp < PrintLo) ok = 1'b0;
        if (cp inside {[DelLo:C1Hi]}) ok = 1'b0;
        if (cp inside {[SurrLo:SurrHi]}) ok = 1'b0;
        if (cp > CpMax) ok = 1'b0;
        return ok;
    endfunction

endpackage

/* hdl/utf8v_in_if.sv */
interface utf8v_in_if;
    import utf8v_pkg::*;

    logic             valid;
    logic             ready;
    logic [ByteW-1:0] data_byte;
    logic             last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* hdl/utf8v_out_if.sv */
interface utf8v_out_if;
    import utf8v_pkg::*;

    logic            valid;
    logic            ready;
    logic            accepted;
    logic [CpW-1:0]  code_point;
    logic [LenW-1:0] seq_length;

    modport source (output valid, output accepted, output code_point, output seq_length,
                    input ready);
    modport sink   (input valid, input accepted, input code_point, input seq_length,
                    output ready);
endinterface

/* hdl/utf8_sequence_validator.sv */
// UTF-8 sequence validator.
// i_in carries one byte of a candidate sequence per beat, with last_byte set
// on the final byte. o_out carries one result beat per sequence, produced by
// the beat that has last_byte set: accepted, the code point (zero when
// rejected) and the byte count, saturating at 5 for five or more bytes.
// Both channels use valid/ready; a beat moves when both are high.
// A byte is captured in an input register and decoded from there against the
// sequence state; the result of a final byte passes from the input register
// to the result register, which drives o_out.
// Throughput: one byte per cycle unless the receiver stalls, set by the single
// input register stage feeding the sequence state and the result register.
// Reset (synchronous, i_rst_n low) clears the sequence state and drops all
// pending beats; the next byte is treated as a lead byte.
// When the receiver stalls, non-final bytes keep flowing into the sequence
// state; a final byte waits in the input register until the result register
// frees, and i_in.ready is low only while it waits there.
module utf8_sequence_validator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    utf8v_in_if.sink             i_in,
    utf8v_out_if.source          o_out
);
    import utf8v_pkg::*;

    logic             r_s1_valid;
    logic [ByteW-1:0] r_s1_byte;
    logic             r_s1_last;

    logic [LenW-1:0]  r_count;
    logic [LenW-1:0]  r_lead_len;
    logic [CpW-1:0]   r_accum;
    logic             r_err;

    logic [LenW-1:0]  n_count;
    logic [LenW-1:0]  n_lead_len;
    logic [CpW-1:0]   n_accum;
    logic             n_err;
    logic             n_ok;

    logic             r_out_valid;
    logic             r_out_accepted;
    logic [CpW-1:0]   r_out_cp;
    logic [LenW-1:0]  r_out_len;

    logic             out_free;
    logic             s1_go;
    logic             in_fire;
    t_lead            lead;

    assign out_free = !r_out_valid || o_out.ready;
    assign s1_go    = r_s1_valid && (!r_s1_last || out_free);
    assign i_in.ready = !r_s1_valid || s1_go;
    assign in_fire  = i_in.valid && i_in.ready;

    assign lead = classify_lead(r_s1_byte);

    always_comb begin
        n_lead_len = r_lead_len;
        n_accum    = r_accum;
        n_err      = r_err;
        n_count    = r_count;
        if (r_count == '0) begin
            n_lead_len = lead.len;
            n_accum    = lead.payload;
            n_err      = r_err | lead.err;
        end else if (r_count < MaxLen) begin
            if (r_s1_byte[7:6] != 2'b10) n_err = 1'b1;
            n_accum = {r_accum[CpW-7:0], r_s1_byte[5:0]};
        end
        if (r_count < CountSat) n_count = r_count + LenW'(1);
        n_ok = !n_err && (n_lead_len != '0) && (n_count <= MaxLen)
            && (n_count == n_lead_len) && value_ok(n_lead_len, n_accum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_byte <= i_in.data_byte;
            r_s1_last <= i_in.last_byte;
        end
    end

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_lead_len <= '0;
            r_accum    <= '0;
            r_err      <= 1'b0;
        end else if (s1_go) begin
            if (r_s1_last) begin
                r_count    <= '0;
                r_lead_len <= '0;
                r_accum    <= '0;
                r_err      <= 1'b0;
            end else begin
                r_count    <= n_count;
                r_lead_len <= n_lead_len;
                r_accum    <= n_accum;
                r_err      <= n_err;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out_accepted <= n_ok;
            r_out_cp       <= n_ok ? n_accum : '0;
            r_out_len      <= n_count;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.accepted   = r_out_accepted;
    assign o_out.code_point = r_out_cp;
    assign o_out.seq_length = r_out_len;

endmodule

/* verif/tb_utf8_sequence_validator.sv */
module tb_utf8_sequence_validator;
    import utf8v_pkg::*;

    typedef struct packed {
        logic            accepted;
        logic [CpW-1:0]  code_point;
        logic [LenW-1:0] seq_length;
    } t_result;

    typedef enum int {SeqWellFormed, SeqCorrupt, SeqNoise} t_seq_kind;
    typedef enum int {MutReplace, MutTruncate, MutExtend} t_mutation;

    localparam int NumMarks = 16;

    logic i_clk;
    logic i_rst_n;

    utf8v_in_if  in_ch ();
    utf8v_out_if out_ch ();

    utf8_sequence_validator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // decoder state mirrored from the block
    logic [LenW-1:0] seen_cnt  = '0;
    logic [LenW-1:0] lead_len  = '0;
    logic [CpW-1:0]  cp_acc    = '0;
    logic            bad_seq   = 1'b0;

    t_result pending_results[$];
    logic [ByteW-1:0] seq_buf[$];

    logic [CpW-1:0] cp_marks[NumMarks] = '{
        21'h00001f, 21'h000020, 21'h00007e, 21'h00007f, 21'h00009f, 21'h0000a0,
        21'h0007ff, 21'h000800, 21'h00d7ff, 21'h00d800, 21'h00dfff, 21'h00e000,
        21'h00ffff, 21'h010000, 21'h10ffff, 21'h110000
    };

    bit idle_on = 1'b1;
    int bytes_sent;
    int seqs_sent;
    int results_seen;
    int accepts_seen;
    int mismatches;
    int faults;
    int waited;
    t_result got;
    t_result want;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic bit printable_scalar(input logic [LenW-1:0] len,
                                            input logic [CpW-1:0] cp);
        if (len == LenW'(2) && cp < Min2) return 1'b0;
        if (len == LenW'(3) && cp < Min3) return 1'b0;
        if (len == LenW'(4) && cp < Min4) return 1'b0;
        if (cp < PrintLo) return 1'b0;
        if (cp >= DelLo && cp <= C1Hi) return 1'b0;
        if (cp >= SurrLo && cp <= SurrHi) return 1'b0;
        return cp <= CpMax;
    endfunction

    function automatic bit decode_byte(input logic [ByteW-1:0] b, input logic fin,
                                       output t_result r);
        bit ok;
        r = '0;
        if (seen_cnt == '0) begin
            if (b[7] == 1'b0) begin
                lead_len = LenW'(1);
                cp_acc   = CpW'(b[6:0]);
            end else if (b[7:5] == 3'b110) begin
                lead_len = LenW'(2);
                cp_acc   = CpW'(b[4:0]);
            end else if (b[7:4] == 4'b1110) begin
                lead_len = LenW'(3);
                cp_acc   = CpW'(b[3:0]);
            end else if (b[7:3] == 5'b11110) begin
                lead_len = LenW'(4);
                cp_acc   = CpW'(b[2:0]);
            end else begin
                lead_len = '0;
                cp_acc   = '0;
                bad_seq  = 1'b1;
            end
        end else if (seen_cnt < MaxLen) begin
            if (b[7:6] != 2'b10) bad_seq = 1'b1;
            cp_acc = {cp_acc[CpW-7:0], b[5:0]};
        end
        if (seen_cnt < CountSat) seen_cnt = seen_cnt + LenW'(1);
        if (!fin) return 1'b0;
        ok = !bad_seq && lead_len != '0 && seen_cnt <= MaxLen && seen_cnt == lead_len
             && printable_scalar(lead_len, cp_acc);
        r.accepted   = ok;
        r.code_point = ok ? cp_acc : '0;
        r.seq_length = seen_cnt;
        seen_cnt = '0;
        lead_len = '0;
        cp_acc   = '0;
        bad_seq  = 1'b0;
        return 1'b1;
    endfunction

    function automatic void append_byte(input logic [ByteW-1:0] b);
        seq_buf = {seq_buf, b};
    endfunction

    task automatic send_byte(input logic [ByteW-1:0] b, input logic fin);
        t_result res;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= fin;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
        if (decode_byte(b, fin, res)) pending_results = {pending_results, res};
    endtask

    task automatic send_seq();
        foreach (seq_buf[i]) send_byte(seq_buf[i], i == seq_buf.size() - 1);
        seqs_sent++;
    endtask

    task automatic encode_scalar(input int len, input logic [CpW-1:0] cp);
        seq_buf.delete();
        case (len)
            1: append_byte({1'b0, cp[6:0]});
            2: begin
                append_byte({3'b110, cp[10:6]});
                append_byte({2'b10, cp[5:0]});
            end
            3: begin
                append_byte({4'b1110, cp[15:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
            default: begin
                append_byte({5'b11110, cp[20:18]});
                append_byte({2'b10, cp[17:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic build_random_seq();
        int pick;
        int len;
        logic [CpW-1:0] cp;
        t_seq_kind kind;
        t_mutation mut;
        pick = $urandom_range(0, 99);
        kind = (pick < 65) ? SeqWellFormed : (pick < 85) ? SeqCorrupt : SeqNoise;
        if (kind == SeqNoise) begin
            seq_buf.delete();
            repeat ($urandom_range(1, 7)) append_byte(ByteW'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 3) == 0) begin
            cp  = cp_marks[$urandom_range(0, NumMarks - 1)];
            len = (cp < Min2) ? 1 : (cp < Min3) ? 2 : (cp < Min4) ? 3 : 4;
            // sometimes an overlong form of the same value
            if (len < 4 && $urandom_range(0, 3) == 0) len = $urandom_range(len + 1, 4);
        end else begin
            len = $urandom_range(1, 4);
            case (len)
                1: cp = CpW'($urandom_range(0, 'h7f));
                2: cp = CpW'($urandom_range(0, 'h7ff));
                3: cp = CpW'($urandom_range(0, 'hffff));
                default: cp = ($urandom_range(0, 3) != 0)
                              ? CpW'($urandom_range('h10000, 'h10ffff))
                              : CpW'($urandom_range(0, 'h1fffff));
            endcase
        end
        encode_scalar(len, cp);
        if (kind == SeqCorrupt) begin
            mut = t_mutation'($urandom_range(0, 2));
            case (mut)
                MutReplace: seq_buf[$urandom_range(0, seq_buf.size() - 1)] =
                    ByteW'($urandom_range(0, 255));
                MutTruncate: begin
                    if (seq_buf.size() > 1) void'(seq_buf.pop_back());
                    else seq_buf[0] = ByteW'($urandom_range(0, 255));
                end
                default: repeat ($urandom_range(1, 3))
                    append_byte({2'b10, 6'($urandom_range(0, 63))});
            endcase
        end
    endtask

    task automatic test_control_and_ascii();
        seq_buf = '{8'h00};
        send_seq();
        seq_buf = '{8'h20};
        send_seq();
        seq_buf = '{8'h7f};
        send_seq();
    endtask

    task automatic test_value_bounds();
        // overlong, surrogate, top scalar, just past the top scalar
        seq_buf = '{8'hc1, 8'hbf};
        send_seq();
        seq_buf = '{8'hed, 8'ha0, 8'h80};
        send_seq();
        seq_buf = '{8'hf4, 8'h8f, 8'hbf, 8'hbf};
        send_seq();
        seq_buf = '{8'hf4, 8'h90, 8'h80, 8'h80};
        send_seq();
    endtask

    task automatic test_malformed();
        // bad leads, bad continuation, extra continuation, too many bytes
        seq_buf = '{8'h80};
        send_seq();
        seq_buf = '{8'hff};
        send_seq();
        seq_buf = '{8'hc3, 8'h41};
        send_seq();
        seq_buf = '{8'hc3, 8'ha9, 8'h80};
        send_seq();
        seq_buf = '{8'hf0, 8'h90, 8'h80, 8'h80, 8'h80};
        send_seq();
    endtask

    task automatic test_random_traffic(input int byte_goal, input bit allow_idle);
        int stop_at;
        stop_at = bytes_sent + byte_goal;
        idle_on = allow_idle;
        while (bytes_sent < stop_at) begin
            if (allow_idle && seqs_sent % 16 == 0) idle_on = ($urandom_range(0, 3) != 0);
            build_random_seq();
            send_seq();
        end
    endtask

    // result receiver with bursty stalls
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.accepted, out_ch.code_point, out_ch.seq_length};
            results_seen++;
            if (got.accepted) accepts_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                faults++;
                if (mismatches <= 10)
                    $display("unexpected result beat: acc=%0b cp=%h len=%0d",
                             got.accepted, got.code_point, got.seq_length);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    faults++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected acc=%0b cp=%h len=%0d",
                                 want.accepted, want.code_point, want.seq_length);
                        $display("          actual   acc=%0b cp=%h len=%0d",
                                 got.accepted, got.code_point, got.seq_length);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.last_byte <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_control_and_ascii();
        test_value_bounds();
        test_malformed();
        test_random_traffic(1560, 1'b1);
        test_random_traffic(300, 1'b0);

        in_ch.valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("results never delivered: %0d", pending_results.size());
            faults += pending_results.size();
        end

        $display("drove %0d bytes in %0d sequences (directed bounds, malformed, random)",
                 bytes_sent, seqs_sent);
        $display("checked %0d result beats, %0d accepted, %0d mismatches",
                 results_seen, accepts_seen, mismatches);
        if (faults == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/utf8v_pkg.sv
hdl/utf8v_in_if.sv
hdl/utf8v_out_if.sv
hdl/utf8_sequence_validator.sv
verif/tb_utf8_sequence_validator.sv
